// ===== design/bsa_pkg.sv =====
package bsa_pkg;
   localparam int AccWidth  = 256;
   localparam int AccHeight = 256;
   localparam int XBits     = 8;
   localparam int YBits     = 8;
   localparam int AddrBits  = XBits + YBits;
   // store is addressed as {row, column}, so it spans the full field range
   localparam int Depth     = 1 << AddrBits;
   // bank word: border mark, weight total, weighted sum
   localparam int SumBits   = 32;
   localparam int TotBits   = 16;
   localparam int WordBits  = 1 + TotBits + SumBits;
   localparam int QuotCap   = 254;
   localparam logic OP_PUSH     = 1'b0;
   localparam logic OP_COLLAPSE = 1'b1;

   typedef logic [WordBits-1:0] word_type;
endpackage

// ===== design/bilinear_splat_accumulator.sv =====
// Bilinear splat accumulator over a 256 x 256 element store held in one
// single-port-read memory. Each element is updated one at a time: a push
// word is issued and then takes four read-modify-write steps, one per
// corner; a collapse word is issued, read, cleared, run through the
// bit-serial divider that forms sum / total, and its result loaded, which
// takes longer while an earlier result word is still stalled. After reset
// the store is swept clear, one element per cycle across all 65536
// elements, during which req_stall is high.
module bilinear_splat_accumulator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  logic [7:0]             req_pixel_value,
   input  logic [7:0]             req_acc_x,
   input  logic [7:0]             req_acc_y,
   input  logic [6:0]             req_weight_nw,
   input  logic [6:0]             req_weight_ne,
   input  logic [6:0]             req_weight_sw,
   input  logic [6:0]             req_weight_se,
   input  logic                   req_edge_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_value
);
   import bsa_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [AddrBits:0]   clr_ff, clr_in;
   logic                op_ff, op_in, edge_ff, edge_in;
   logic [7:0]          val_ff, val_in;
   logic [XBits-1:0]    x_ff, x_in;
   logic [YBits-1:0]    y_ff, y_in;
   logic [6:0]          w_ff [4];
   logic [6:0]          w_in [4];
   logic [1:0]          corner_ff, corner_in;
   logic [SumBits-1:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [TotBits-1:0]  div_ff, div_in;
   logic [5:0]          bit_ff, bit_in;
   logic                res_ok_ff, res_ok_in;
   logic [7:0]          out_ff, out_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en;
   logic [AddrBits-1:0] wr_addr, rd_addr;
   word_type            wr_data, rd_data;

   logic [XBits:0]      cx;
   logic [YBits:0]      cy;
   logic                in_store;
   logic [6:0]          cw;
   logic [SumBits-1:0]  rd_sum;
   logic [TotBits-1:0]  rd_tot;
   logic                rd_mark;
   logic [SumBits:0]    rem_sh;
   logic [SumBits:0]    div_ext;

   bsa_ram #(.Width(WordBits), .Depth(Depth)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // current corner coordinates
   always_comb begin
      cx = {1'b0, x_ff} + {{XBits{1'b0}}, corner_ff[0]};
      cy = {1'b0, y_ff} + {{YBits{1'b0}}, corner_ff[1]};
      in_store = (cx < (XBits+1)'(AccWidth)) && (cy < (YBits+1)'(AccHeight));
      cw = w_ff[corner_ff];
      rd_mark = rd_data[WordBits-1];
      rd_tot  = rd_data[SumBits +: TotBits];
      rd_sum  = rd_data[SumBits-1:0];
      rem_sh  = {rem_ff, quo_ff[SumBits-1]};
      div_ext = {{(SumBits+1-TotBits){1'b0}}, div_ff};
   end

   assign rd_addr   = {cy[YBits-1:0], cx[XBits-1:0]};
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_value = out_ff;

   // sequencer
   always_comb begin
      state_in = state_ff; clr_in = clr_ff; op_in = op_ff; edge_in = edge_ff;
      val_in = val_ff; x_in = x_ff; y_in = y_ff; w_in = w_ff;
      corner_in = corner_ff; rem_in = rem_ff; quo_in = quo_ff; div_in = div_ff;
      bit_in = bit_ff; res_ok_in = res_ok_ff; out_in = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en = 1'b0; wr_addr = rd_addr; wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[AddrBits-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AddrBits+1)'(Depth - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_op; edge_in = req_edge_pixel; val_in = req_pixel_value;
               x_in = req_acc_x; y_in = req_acc_y;
               w_in[0] = req_weight_nw; w_in[1] = req_weight_ne;
               w_in[2] = req_weight_sw; w_in[3] = req_weight_se;
               corner_in = 2'd0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (op_ff == OP_PUSH) begin
               wr_en = in_store;
               wr_data = {rd_mark | edge_ff, rd_tot + TotBits'(cw),
                          rd_sum + SumBits'(cw) * SumBits'(val_ff)};
               corner_in = corner_ff + 1'b1;
               state_in = (corner_ff == 2'd3) ? ST_IDLE : ST_READ;
            end else begin
               wr_en = in_store;
               res_ok_in = in_store && (rd_tot != '0) && !rd_mark;
               rem_in = '0; quo_in = rd_sum; div_in = rd_tot; bit_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= div_ext) rem_in = SumBits'(rem_sh - div_ext);
            else rem_in = rem_sh[SumBits-1:0];
            quo_in = {quo_ff[SumBits-2:0], (rem_sh >= div_ext)};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 6'd31) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (!res_ok_ff) out_in = '0;
               else if (quo_ff >= SumBits'(QuotCap)) out_in = 8'(QuotCap + 1);
               else out_in = quo_ff[7:0] + 8'd1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in; edge_ff <= edge_in; val_ff <= val_in; x_ff <= x_in;
      y_ff <= y_in; w_ff <= w_in; corner_ff <= corner_in; rem_ff <= rem_in;
      quo_ff <= quo_in; div_ff <= div_in; bit_ff <= bit_in;
      res_ok_ff <= res_ok_in; out_ff <= out_in;
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall) else $error("accept during clear");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_OUT) else $error("stray word");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && $past(state_ff) == ST_DIV |-> $past(bit_ff) == 6'd31)
      else $error("divider length");
endmodule

// ===== design/bsa_ram.sv =====
module bsa_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
